[rtl/hkrd_pkg.sv]
// Shared types and constants for the keyboard report key change detector.
`timescale 1ns / 1ps
package hkrd_pkg;
	localparam int IN_SLOTS = 6;
	localparam int KEY_W = 8;
	localparam int CNT_W = 3;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;
endpackage

[rtl/hkrd_in_if.sv]
// Report channel: six keycode slots and a count of valid leading slots.
`timescale 1ns / 1ps
interface hkrd_in_if;
	import hkrd_pkg::*;
	logic valid;
	logic ready;
	key_t key_0;
	key_t key_1;
	key_t key_2;
	key_t key_3;
	key_t key_4;
	key_t key_5;
	cnt_t key_count;

	modport source (output valid, key_0, key_1, key_2, key_3, key_4, key_5, key_count,
		input ready);
	modport sink (input valid, key_0, key_1, key_2, key_3, key_4, key_5, key_count,
		output ready);
endinterface

[rtl/hkrd_out_if.sv]
// Event channel: one key press or release per transfer.
`timescale 1ns / 1ps
interface hkrd_out_if;
	import hkrd_pkg::*;
	logic valid;
	logic ready;
	key_t event_key;
	logic is_press;
	logic last_event;

	modport source (output valid, event_key, is_press, last_event, input ready);
	modport sink (input valid, event_key, is_press, last_event, output ready);
endinterface

[rtl/hkrd_lane.sv]
// One compare lane: flags a non-zero key that is absent from a list.
`timescale 1ns / 1ps
module hkrd_lane #(
	parameter int LIST_LEN = 6
) (
	input  logic                    en,
	input  hkrd_pkg::key_t          key,
	input  hkrd_pkg::key_t          list [LIST_LEN],
	input  logic [LIST_LEN-1:0]     list_vld,
	output logic                    flag
);
	import hkrd_pkg::*;

	logic [LIST_LEN-1:0] hit;

	always_comb begin
		for (int k = 0; k < LIST_LEN; k++) begin
			hit[k] = list_vld[k] && (list[k] == key);
		end
	end

	assign flag = en && (key != '0) && !(|hit);
endmodule

[rtl/hkrd_merge.sv]
// Merge stage: holds the lane flags of one report and sends them out in order.
`timescale 1ns / 1ps
module hkrd_merge #(
	parameter int RELEASE_LANES = 6,
	parameter int PRESS_LANES = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [RELEASE_LANES+PRESS_LANES-1:0] load_mask,
	input  hkrd_pkg::key_t         load_key [RELEASE_LANES+PRESS_LANES],
	output logic                   job_free,
	hkrd_out_if.source             out_ch
);
	import hkrd_pkg::*;

	localparam int N = RELEASE_LANES + PRESS_LANES;
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] job_mask_q;
	key_t         job_key_q [N];
	logic [N-1:0] mask_next;
	logic [N-1:0] pick_bit;
	logic [IDX_W-1:0] pick_idx;
	logic         found;
	logic         pop;
	logic         out_valid_q;
	key_t         out_key_q;
	logic         out_press_q;
	logic         out_last_q;

	always_comb begin
		pick_idx = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if (job_mask_q[k]) begin
				pick_idx = IDX_W'(k);
			end
		end
	end

	assign found = |job_mask_q;
	assign pick_bit = N'(1) << pick_idx;
	assign pop = found && (!out_valid_q || out_ch.ready);
	assign mask_next = pop ? (job_mask_q & ~pick_bit) : job_mask_q;
	assign job_free = (mask_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_mask_q <= '0;
		end else if (load) begin
			job_mask_q <= load_mask;
		end else begin
			job_mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_key_q <= load_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_key_q   <= job_key_q[pick_idx];
			out_press_q <= (pick_idx >= IDX_W'(RELEASE_LANES));
			out_last_q  <= ((job_mask_q & ~pick_bit) == '0);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.event_key  = out_key_q;
	assign out_ch.is_press   = out_press_q;
	assign out_ch.last_event = out_last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> job_free)
		else $error("report loaded over pending events");

	a_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (job_key_q[pick_idx] != '0))
		else $error("empty keycode selected for an event");

	a_fill_output: assert property (@(posedge clk) disable iff (!arst_n)
		(found && !out_valid_q) |=> out_valid_q)
		else $error("pending event not moved to output register");

	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_key_q != '0))
		else $error("event with zero keycode presented");
endmodule

[rtl/hid_key_report_diff.sv]
// Top level of the keyboard report key change detector.
//
// channel  dir  transfer                      payload
// in_ch    in   one report                    key_0..key_5, key_count
// out_ch   out  one press or release event    event_key, is_press, last_event
//
// A report is compared in the cycle it is taken. Its events then pass through the
// pending-event register and the output register one per cycle while out_ch does
// not stall, releases in stored slot order, then presses. A report causes 0 to 12
// events with six slots; the next report is taken in the cycle its last event moves.
// arst_n clears the held keys, the pending events and the output valid flag.
// A stall on out_ch holds the output register and, while events are pending, back-pressures in_ch.
`timescale 1ns / 1ps
module hid_key_report_diff #(
	parameter int KEY_SLOTS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	hkrd_in_if.sink    in_ch,
	hkrd_out_if.source out_ch
);
	import hkrd_pkg::*;

	localparam int EFF_SLOTS = (KEY_SLOTS < IN_SLOTS) ? KEY_SLOTS : IN_SLOTS;
	localparam int N = KEY_SLOTS + IN_SLOTS;

	key_t                  fresh [IN_SLOTS];
	logic [IN_SLOTS-1:0]   fresh_vld;
	cnt_t                  cnt;
	key_t                  held_q [KEY_SLOTS];
	logic [KEY_SLOTS-1:0]  held_all;
	logic [N-1:0]          job_mask;
	key_t                  job_key [N];
	logic                  job_free;
	logic                  accept;

	assign fresh[0] = in_ch.key_0;
	assign fresh[1] = in_ch.key_1;
	assign fresh[2] = in_ch.key_2;
	assign fresh[3] = in_ch.key_3;
	assign fresh[4] = in_ch.key_4;
	assign fresh[5] = in_ch.key_5;

	assign cnt = (in_ch.key_count > CNT_W'(EFF_SLOTS)) ? CNT_W'(EFF_SLOTS) : in_ch.key_count;
	assign held_all = '1;
	assign accept = in_ch.valid && job_free;
	assign in_ch.ready = job_free;

	for (genvar j = 0; j < IN_SLOTS; j++) begin : g_press
		assign fresh_vld[j] = (CNT_W'(j) < cnt);
		assign job_key[KEY_SLOTS+j] = fresh[j];

		hkrd_lane #(.LIST_LEN(KEY_SLOTS)) u_lane (
			.en       (fresh_vld[j]),
			.key      (fresh[j]),
			.list     (held_q),
			.list_vld (held_all),
			.flag     (job_mask[KEY_SLOTS+j])
		);
	end

	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_release
		assign job_key[i] = held_q[i];

		hkrd_lane #(.LIST_LEN(IN_SLOTS)) u_lane (
			.en       (1'b1),
			.key      (held_q[i]),
			.list     (fresh),
			.list_vld (fresh_vld),
			.flag     (job_mask[i])
		);

		if (i < IN_SLOTS) begin : g_store
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					held_q[i] <= '0;
				end else if (accept) begin
					held_q[i] <= fresh_vld[i] ? fresh[i] : '0;
				end
			end
		end else begin : g_zero
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					held_q[i] <= '0;
				end
			end
		end
	end

	hkrd_merge #(
		.RELEASE_LANES (KEY_SLOTS),
		.PRESS_LANES   (IN_SLOTS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_mask (job_mask),
		.load_key  (job_key),
		.job_free  (job_free),
		.out_ch    (out_ch)
	);
endmodule
